@@ design/srt_pkg.sv @@
`timescale 1ns / 1ps

package srt_pkg;

  // Operation codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam int unsigned SLOT_COUNT_DEF = 16;
  // Slot index field in the candidate record, wide enough for the largest table
  localparam int unsigned SLOT_IDX_W = 6;
  localparam int unsigned CLOCK_W    = 24;
  localparam logic [CLOCK_W-1:0] CLOCK_MAX = 24'hFF_FFFF;

  typedef struct packed {
    logic [7:0]  job_id;
    logic [15:0] burst;
    logic [15:0] arrival;
  } load_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic dec;
    logic is_cur;
  } cell_ctrl_t;

  // Best job seen so far, handed from cell to cell during a scan
  typedef struct packed {
    logic                  found;
    logic [SLOT_IDX_W-1:0] slot;
    logic [15:0]           rem;
    logic [7:0]            job_id;
    logic [15:0]           burst;
    logic [15:0]           arrival;
  } cand_t;

endpackage

@@ design/srt_cell.sv @@
`timescale 1ns / 1ps

module srt_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  srt_pkg::cell_ctrl_t           ctrl_i,
  input  srt_pkg::load_t                load_i,
  input  logic [srt_pkg::CLOCK_W-1:0]   clock_i,
  input  logic                          cand_valid_i,
  input  srt_pkg::cand_t                cand_i,
  output logic                          cand_valid_o,
  output srt_pkg::cand_t                cand_o,
  output logic                          pending_o
);

  logic [7:0]     job_id_q;
  logic [15:0]    burst_q;
  logic [15:0]    arrival_q;
  logic [15:0]    rem_q;
  logic           eligible;
  logic           take;
  srt_pkg::cand_t cand_d;
  srt_pkg::cand_t cand_q;
  logic           cand_valid_q;

  assign eligible = (rem_q != 16'd0) && (srt_pkg::CLOCK_W'(arrival_q) <= clock_i);

  // Strictly shorter wins; on a tie only the running job takes over
  assign take = eligible && (!cand_i.found || (rem_q < cand_i.rem) ||
                             ((rem_q == cand_i.rem) && ctrl_i.is_cur));

  always_comb begin
    cand_d = cand_i;
    if (take) begin
      cand_d.found   = 1'b1;
      cand_d.slot    = srt_pkg::SLOT_IDX_W'(IDX);
      cand_d.rem     = rem_q;
      cand_d.job_id  = job_id_q;
      cand_d.burst   = burst_q;
      cand_d.arrival = arrival_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_id_q  <= '0;
      burst_q   <= '0;
      arrival_q <= '0;
      rem_q     <= '0;
    end else if (ctrl_i.clear) begin
      job_id_q  <= '0;
      burst_q   <= '0;
      arrival_q <= '0;
      rem_q     <= '0;
    end else if (ctrl_i.load) begin
      job_id_q  <= load_i.job_id;
      burst_q   <= load_i.burst;
      arrival_q <= load_i.arrival;
      rem_q     <= load_i.burst;
    end else if (ctrl_i.dec) begin
      rem_q <= rem_q - 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_valid_q <= 1'b0;
    end else begin
      cand_valid_q <= cand_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
  end

  assign cand_valid_o = cand_valid_q;
  assign cand_o       = cand_q;
  assign pending_o    = (rem_q != 16'd0);

endmodule

@@ design/shortest_remaining_time_scheduler_top.sv @@
`timescale 1ns / 1ps
// Load, clear and unknown items: result registered at the transfer edge, one item per cycle
// while the output is not stalled. Tick items: the candidate walks the row of SLOT_COUNT
// slot cells, one cell per cycle, and the result is registered as it leaves the last cell;
// no new item is taken until the scan is over.
// Reset (asynchronous, active low) empties every slot, zeroes the tick clock and the
// running claim, and drops any pending result.

module shortest_remaining_time_scheduler_top #(
  parameter int unsigned SLOT_COUNT = srt_pkg::SLOT_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [3:0]  slot_i,
  input  logic [7:0]  job_id_i,
  input  logic [15:0] burst_length_i,
  input  logic [15:0] arrival_tick_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  ran_job_id_o,
  output logic        idle_o,
  output logic        job_finished_o,
  output logic [23:0] wait_ticks_o,
  output logic        all_done_o,
  output logic [23:0] clock_now_o
);

  localparam int unsigned SW = $clog2(SLOT_COUNT);
  localparam int unsigned CW = $clog2(SLOT_COUNT + 1);
  localparam int unsigned WW = srt_pkg::CLOCK_W + 2;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                        state_q, state_d;
  logic                        start_q;
  logic [srt_pkg::CLOCK_W-1:0] clock_q, clock_d;
  logic [SW-1:0]               cur_slot_q, cur_slot_d;
  logic                        have_cur_q, have_cur_d;
  logic [CW-1:0]               cnt_q, cnt_d;

  logic                        out_valid_q;
  logic [7:0]                  out_ran_q;
  logic                        out_idle_q;
  logic                        out_fin_q;
  logic [23:0]                 out_wait_q;
  logic                        out_all_done_q;
  logic [23:0]                 out_clock_q;

  logic                        accept;
  logic                        do_load;
  logic                        do_clear;
  logic                        do_tick;
  logic                        in_range;
  logic [SW-1:0]               slot_idx;
  logic                        scan_done;
  logic                        finished;
  logic [WW-1:0]               wait_full;
  logic [23:0]                 wait_val;
  logic [SW-1:0]               best_slot;
  srt_pkg::load_t              load_data;

  srt_pkg::cand_t              cand_w [SLOT_COUNT+1];
  logic [SLOT_COUNT:0]         cval_w;
  logic [SLOT_COUNT-1:0]       pend_vec;
  srt_pkg::cell_ctrl_t         ctrl_w [SLOT_COUNT];

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = (int'(slot_i) < SLOT_COUNT);
  assign slot_idx   = SW'(slot_i);
  assign do_load    = accept && (opcode_i == srt_pkg::OP_LOAD) && in_range;
  assign do_clear   = accept && (opcode_i == srt_pkg::OP_CLEAR);
  assign do_tick    = accept && (opcode_i == srt_pkg::OP_TICK);

  assign load_data.job_id  = job_id_i;
  assign load_data.burst   = burst_length_i;
  assign load_data.arrival = arrival_tick_i;

  assign scan_done = cval_w[SLOT_COUNT];
  assign best_slot = cand_w[SLOT_COUNT].slot[SW-1:0];
  assign finished  = cand_w[SLOT_COUNT].found && (cand_w[SLOT_COUNT].rem == 16'd1);

  // Wait = finish - burst - arrival; clamp a negative value at zero
  assign wait_full = WW'(clock_q) + WW'(1) - WW'(cand_w[SLOT_COUNT].burst)
                   - WW'(cand_w[SLOT_COUNT].arrival);
  assign wait_val  = wait_full[WW-1] ? 24'd0 : wait_full[23:0];

  assign cand_w[0] = '0;
  assign cval_w[0] = start_q;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    assign ctrl_w[i].clear  = do_clear;
    assign ctrl_w[i].load   = do_load && (slot_idx == SW'(i));
    assign ctrl_w[i].dec    = scan_done && cand_w[SLOT_COUNT].found && (best_slot == SW'(i));
    assign ctrl_w[i].is_cur = have_cur_q && (cur_slot_q == SW'(i));

    srt_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl_w[i]),
      .load_i       (load_data),
      .clock_i      (clock_q),
      .cand_valid_i (cval_w[i]),
      .cand_i       (cand_w[i]),
      .cand_valid_o (cval_w[i+1]),
      .cand_o       (cand_w[i+1]),
      .pending_o    (pend_vec[i])
    );
  end

  always_comb begin
    state_d    = state_q;
    clock_d    = clock_q;
    cur_slot_d = cur_slot_q;
    have_cur_d = have_cur_q;
    cnt_d      = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (do_clear) begin
          clock_d    = '0;
          cur_slot_d = '0;
          have_cur_d = 1'b0;
          cnt_d      = '0;
        end else if (do_load) begin
          cnt_d = cnt_q - CW'(pend_vec[slot_idx]) + CW'(burst_length_i != 16'd0);
          if (have_cur_q && (cur_slot_q == slot_idx)) begin
            have_cur_d = 1'b0;
          end
        end else if (do_tick) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_IDLE;
          if (clock_q != srt_pkg::CLOCK_MAX) begin
            clock_d = clock_q + 24'd1;
          end
          if (!cand_w[SLOT_COUNT].found) begin
            have_cur_d = 1'b0;
          end else begin
            cur_slot_d = best_slot;
            have_cur_d = !finished;
            if (finished) begin
              cnt_d = cnt_q - CW'(1);
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      start_q    <= 1'b0;
      clock_q    <= '0;
      cur_slot_q <= '0;
      have_cur_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      state_q    <= state_d;
      start_q    <= do_tick;
      clock_q    <= clock_d;
      cur_slot_q <= cur_slot_d;
      have_cur_q <= have_cur_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((accept && !do_tick) || ((state_q == ST_SCAN) && scan_done)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !do_tick) begin
      out_ran_q      <= '0;
      out_idle_q     <= 1'b0;
      out_fin_q      <= 1'b0;
      out_wait_q     <= '0;
      out_all_done_q <= (cnt_d == '0);
      out_clock_q    <= clock_q;
    end else if ((state_q == ST_SCAN) && scan_done) begin
      out_ran_q      <= cand_w[SLOT_COUNT].found ? cand_w[SLOT_COUNT].job_id : 8'd0;
      out_idle_q     <= !cand_w[SLOT_COUNT].found;
      out_fin_q      <= finished;
      out_wait_q     <= finished ? wait_val : 24'd0;
      out_all_done_q <= (cnt_d == '0);
      out_clock_q    <= clock_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign ran_job_id_o   = out_ran_q;
  assign idle_o         = out_idle_q;
  assign job_finished_o = out_fin_q;
  assign wait_ticks_o   = out_wait_q;
  assign all_done_o     = out_all_done_q;
  assign clock_now_o    = out_clock_q;

  // A launched scan token passes each cell register in turn and leaves the last cell
  a_scan_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |-> ##SLOT_COUNT scan_done)
    else $error("scan token did not reach the end of the row on time");

  // The pending-slot count is zero exactly when no cell has work left
  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) == (pend_vec == '0))
    else $error("pending count disagrees with slot contents");

  // A held claim always points at a slot with work left
  a_claim_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_cur_q |-> pend_vec[cur_slot_q])
    else $error("running claim on an empty slot");

  // Unless the output is stalled, a finishing result is not flagged idle and does not block input
  a_fin_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_fin_q |-> !out_idle_q && !in_stall_o || out_stall_i)
    else $error("finished result flagged idle or blocking input");

endmodule

@@ sim/shortest_remaining_time_scheduler_top_tb.sv @@
`timescale 1ns / 1ps

module shortest_remaining_time_scheduler_top_tb;

  localparam int unsigned SLOTS        = srt_pkg::SLOT_COUNT_DEF;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int          RANDOM_ITEMS = 850;
  localparam int          CYCLE_LIMIT  = 300000;
  localparam int          HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [7:0]  ran_job_id;
    logic        idle;
    logic        job_finished;
    logic [23:0] wait_ticks;
    logic        all_done;
    logic [23:0] clock_now;
  } sched_outcome_t;

  class srtf_scoreboard;
    logic [7:0]     job_of       [SLOTS];
    logic [15:0]    burst_of     [SLOTS];
    logic [15:0]    arrival_of   [SLOTS];
    logic [15:0]    remaining_of [SLOTS];
    logic [23:0]    tick_now;
    logic [3:0]     running_slot;
    bit             running_valid;
    sched_outcome_t expected_q[$];
    int             fail_count;

    function new();
      fail_count = 0;
      empty_table();
    endfunction

    function void empty_table();
      foreach (job_of[s]) begin
        job_of[s]       = '0;
        burst_of[s]     = '0;
        arrival_of[s]   = '0;
        remaining_of[s] = '0;
      end
      tick_now      = '0;
      running_slot  = '0;
      running_valid = 1'b0;
    endfunction

    function bit ready(int s);
      return remaining_of[s] != 0 && {8'd0, arrival_of[s]} <= tick_now;
    endfunction

    function sched_outcome_t schedule_step(logic [1:0] op, logic [3:0] slot, logic [7:0] id,
                                           logic [15:0] burst, logic [15:0] arrival);
      sched_outcome_t r;
      int             best;
      int             best_rem;
      bit             found;
      longint         late;
      r = '0;
      r.clock_now = tick_now;
      case (op)
        srt_pkg::OP_LOAD: begin
          job_of[slot]       = id;
          burst_of[slot]     = burst;
          arrival_of[slot]   = arrival;
          remaining_of[slot] = burst;
          // reloading the running slot drops its claim
          if (running_valid && running_slot == slot) running_valid = 1'b0;
        end
        srt_pkg::OP_CLEAR: empty_table();
        srt_pkg::OP_TICK: begin
          found    = 1'b0;
          best     = 0;
          best_rem = 32'h1_0000;
          // the running job keeps the unit unless something strictly shorter is ready
          if (running_valid && ready(running_slot)) begin
            best     = running_slot;
            best_rem = remaining_of[best];
            found    = 1'b1;
          end
          for (int s = 0; s < SLOTS; s++) begin
            if (ready(s) && remaining_of[s] < best_rem) begin
              best     = s;
              best_rem = remaining_of[s];
              found    = 1'b1;
            end
          end
          if (!found) begin
            r.idle        = 1'b1;
            running_valid = 1'b0;
          end else begin
            remaining_of[best] = remaining_of[best] - 16'd1;
            r.ran_job_id       = job_of[best];
            running_slot       = best[3:0];
            running_valid      = 1'b1;
            if (remaining_of[best] == 0) begin
              late = longint'(tick_now) + 1 - longint'(burst_of[best])
                     - longint'(arrival_of[best]);
              r.job_finished = 1'b1;
              r.wait_ticks   = (late < 0) ? 24'd0 : late[23:0];
              running_valid  = 1'b0;
            end
          end
          if (tick_now < srt_pkg::CLOCK_MAX) tick_now = tick_now + 24'd1;
        end
        default: ;
      endcase
      r.all_done = 1'b1;
      foreach (remaining_of[s]) if (remaining_of[s] != 0) r.all_done = 1'b0;
      return r;
    endfunction

    function void note_transfer(logic [1:0] op, logic [3:0] slot, logic [7:0] id,
                                logic [15:0] burst, logic [15:0] arrival);
      expected_q.push_back(schedule_step(op, slot, id, burst, arrival));
    endfunction

    task report(string what);
      $display("[%0t] MISMATCH %s", $realtime, what);
      fail_count++;
    endtask

    task compare(string field, logic [23:0] got, logic [23:0] want, logic [23:0] at);
      if (got !== want)
        report($sformatf("%s got %0h want %0h (item at tick %0d)", field, got, want, at));
    endtask

    task check_outcome(sched_outcome_t got);
      sched_outcome_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing pending, job %0h clock %0d",
                         got.ran_job_id, got.clock_now));
        return;
      end
      want = expected_q.pop_front();
      compare("ran_job_id", 24'(got.ran_job_id), 24'(want.ran_job_id), want.clock_now);
      compare("idle", 24'(got.idle), 24'(want.idle), want.clock_now);
      compare("job_finished", 24'(got.job_finished), 24'(want.job_finished), want.clock_now);
      compare("wait_ticks", got.wait_ticks, want.wait_ticks, want.clock_now);
      compare("all_done", 24'(got.all_done), 24'(want.all_done), want.clock_now);
      compare("clock_now", got.clock_now, want.clock_now, want.clock_now);
    endtask
  endclass

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [1:0]  opcode_i       = '0;
  logic [3:0]  slot_i         = '0;
  logic [7:0]  job_id_i       = '0;
  logic [15:0] burst_length_i = '0;
  logic [15:0] arrival_tick_i = '0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [7:0]  ran_job_id_o;
  logic        idle_o;
  logic        job_finished_o;
  logic [23:0] wait_ticks_o;
  logic        all_done_o;
  logic [23:0] clock_now_o;

  srtf_scoreboard sb;
  int             items_sent      = 0;
  int             burst_left      = 0;
  int             cycle_count     = 0;
  bit             hold_off_wanted = 1'b0;

  shortest_remaining_time_scheduler_top #(
    .SLOT_COUNT(SLOTS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .slot_i        (slot_i),
    .job_id_i      (job_id_i),
    .burst_length_i(burst_length_i),
    .arrival_tick_i(arrival_tick_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .ran_job_id_o  (ran_job_id_o),
    .idle_o        (idle_o),
    .job_finished_o(job_finished_o),
    .wait_ticks_o  (wait_ticks_o),
    .all_done_o    (all_done_o),
    .clock_now_o   (clock_now_o)
  );

  always #4 clk_i = ~clk_i;

  // Offer one item, hold it until the transfer, then maybe open a gap
  task automatic send_item(input logic [1:0] op, input logic [3:0] slot, input logic [7:0] id,
                           input logic [15:0] burst, input logic [15:0] arrival);
    int gap;
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    slot_i         <= slot;
    job_id_i       <= id;
    burst_length_i <= burst;
    arrival_tick_i <= arrival;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_transfer(op, slot, id, burst, arrival);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic tick_item();
    send_item(srt_pkg::OP_TICK, 4'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_q.size() != 0);
  endtask

  // Load a handful of jobs near the current tick, then run them down
  task automatic run_job_set();
    int          jobs;
    int          ticks;
    logic [15:0] b;
    logic [15:0] a;
    logic [3:0]  s;
    jobs  = $urandom_range(1, 6);
    ticks = 0;
    for (int j = 0; j < jobs; j++) begin
      case ($urandom_range(0, 19))
        0:       b = 16'd0;
        1:       b = 16'($urandom);
        default: b = 16'($urandom_range(1, 8));
      endcase
      if ($urandom_range(0, 19) == 0) a = 16'($urandom);
      else a = 16'(sb.tick_now + $urandom_range(0, 8));
      if (b <= 8) ticks += b;
      send_item(srt_pkg::OP_LOAD, 4'($urandom), 8'($urandom), b, a);
    end
    ticks += $urandom_range(0, 8);
    if (ticks > 48) ticks = 48;
    for (int t = 0; t < ticks; t++) begin
      if ($urandom_range(0, 15) == 0) begin
        // late arrival, often over the running slot
        s = ($urandom_range(0, 1) == 0) ? sb.running_slot : 4'($urandom);
        send_item(srt_pkg::OP_LOAD, s, 8'($urandom), 16'($urandom_range(1, 6)),
                  16'(sb.tick_now + $urandom_range(0, 3)));
      end
      tick_item();
    end
    if ($urandom_range(0, 4) == 0)
      send_item(srt_pkg::OP_CLEAR, 4'($urandom), 8'($urandom), 16'($urandom),
                16'($urandom));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_outcome(sched_outcome_t'({ran_job_id_o, idle_o, job_finished_o, wait_ticks_o,
                                         all_done_o, clock_now_o}));
  end

  initial begin : receiver
    int seg_left;
    int mode;
    int hold_left;
    seg_left  = 0;
    mode      = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_wanted) begin
        hold_off_wanted = 1'b0;
        hold_left       = HOLD_CYCLES;
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 64);
        mode     = $urandom_range(0, 3);
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= (seg_left % 3 == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    bit held;
    bit paused;
    int pick;
    held   = 1'b0;
    paused = 1'b0;
    sb     = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tick_item();
    send_item(OP_UNUSED, 4'hF, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_item(srt_pkg::OP_LOAD, 4'd0, 8'hFF, 16'd0, 16'd0);        // zero burst never runs
    send_item(srt_pkg::OP_LOAD, 4'hF, 8'h00, 16'hFFFF, 16'hFFFF);  // never arrives
    send_item(srt_pkg::OP_LOAD, 4'd3, 8'hA5, 16'd2, 16'd0);
    send_item(srt_pkg::OP_LOAD, 4'd9, 8'h5A, 16'd2, 16'd0);        // tie: lowest slot wins
    repeat (3) tick_item();
    send_item(srt_pkg::OP_LOAD, 4'd9, 8'h5A, 16'd3, 16'd0);        // over the running slot
    send_item(srt_pkg::OP_LOAD, 4'd4, 8'h3C, 16'd3, 16'd0);
    tick_item();
    send_item(srt_pkg::OP_LOAD, 4'd1, 8'h77, 16'd1, 16'd7);        // shorter job arrives later
    repeat (3) tick_item();
    send_item(srt_pkg::OP_LOAD, 4'd2, 8'hC3, 16'hFFFF, 16'd0);
    repeat (4) tick_item();
    send_item(srt_pkg::OP_CLEAR, 4'hF, 8'hFF, 16'hFFFF, 16'hFFFF);
    tick_item();
    send_item(OP_UNUSED, 4'd0, 8'd0, 16'd0, 16'd0);
    drain();

    while (items_sent < RANDOM_ITEMS) begin
      if (!held && items_sent > 300) begin
        held            = 1'b1;
        hold_off_wanted = 1'b1;
      end
      if (!paused && items_sent > 550) begin
        paused = 1'b1;
        drain();
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        run_job_set();
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 4))
          send_item(2'($urandom), 4'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        send_item(($urandom_range(0, 1) == 0) ? srt_pkg::OP_CLEAR : OP_UNUSED, 4'($urandom),
                  8'($urandom), 16'($urandom), 16'($urandom));
      end
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (sb.fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
